// ----- design/scanpp_pkg.sv -----
// Package: shared constants, types and tables of the scan polar-to-pixel unit.
`default_nettype none
package scanpp_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int RANGE_BITS_DEF = 16;

  localparam int CFG_DATA_W = 16;
  localparam int RANGE_W    = 16;
  localparam int SCALE_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int XPOS_W     = 17;
  localparam int PIX_W      = 18;
  localparam int ITERS      = 16;
  localparam int ITER_W     = 4;
  localparam int Z_W        = 18;

  localparam int INV_GAIN  = 39797;
  localparam int PIX_MAX   = 131071;
  localparam int PIX_MIN   = -131072;
  localparam int QTR_TURN  = 16384;
  localparam int HALF_TURN = 32768;

  typedef enum logic [2:0] {
    CFG_ANGLE_START  = 3'd0,
    CFG_ANGLE_STEP   = 3'd1,
    CFG_MIN_RANGE    = 3'd2,
    CFG_MAX_RANGE    = 3'd3,
    CFG_PIXEL_SCALE  = 3'd4,
    CFG_IMAGE_CENTER = 3'd5,
    CFG_IMAGE_SIZE   = 3'd6,
    CFG_FLIP_ROWS    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                  wr;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_SCALE,
    ST_PIXEL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              rotate;
    logic              scale;
    logic              pixel;
    logic              emit;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      4'd14:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- design/scan_polar_to_pixel_unit.sv -----
// Top level: lidar range sample to Cartesian point and image pixel.
// Input channel: in_valid / in_stall with in_range_sample (1/1024 m) and
//   in_scan_start; a transfer happens when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with x_pos, y_pos, in_range,
//   pixel_col, pixel_row and in_image; one result per input transfer.
// Configuration: cfg_valid / cfg_ready write port, cfg_index selects the
//   register, cfg_data carries the value; cfg_ready is always high. Write
//   only while the unit is idle.
// Sequence: the transfer edge loads the gain product and updated angle,
//   then 16 iterations of the shared CORDIC stage, scaling, pixel multiply
//   and result write into the registered output.
// Next input: one item at a time; a new input is taken in the cycle
//   after the previous item is written to the output register, even while
//   that result still waits to be taken.
// Stall: a held result keeps the next item in its final cycle until the
//   output register frees up; in_stall stays high meanwhile.
// Reset: synchronous, active low; configuration registers return to their defaults,
//   the beam angle clears to zero and the output channel empties.
`default_nettype none
module scan_polar_to_pixel_unit #(
  parameter int ANGLE_BITS = scanpp_pkg::ANGLE_BITS_DEF,
  parameter int RANGE_BITS = scanpp_pkg::RANGE_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic [scanpp_pkg::RANGE_W-1:0]        in_range_sample,
  input  wire logic                                  in_scan_start,
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic signed [scanpp_pkg::XPOS_W-1:0]  out_x_pos,
  output      logic signed [scanpp_pkg::XPOS_W-1:0]  out_y_pos,
  output      logic                                  out_in_range,
  output      logic signed [scanpp_pkg::PIX_W-1:0]   out_pixel_col,
  output      logic signed [scanpp_pkg::PIX_W-1:0]   out_pixel_row,
  output      logic                                  out_in_image,
  input  wire logic                                  cfg_valid,
  output      logic                                  cfg_ready,
  input  wire logic [2:0]                            cfg_index,
  input  wire logic [scanpp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scanpp_pkg::*;

  cmd_t    cmd;
  cfg_wr_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid;
  assign cfg.idx   = cfg_idx_t'(cfg_index);
  assign cfg.data  = cfg_data;

  scanpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  scanpp_datapath #(
    .ANGLE_BITS (ANGLE_BITS),
    .RANGE_BITS (RANGE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .range_sample (in_range_sample),
    .scan_start   (in_scan_start),
    .x_pos        (out_x_pos),
    .y_pos        (out_y_pos),
    .in_range     (out_in_range),
    .pixel_col    (out_pixel_col),
    .pixel_row    (out_pixel_row),
    .in_image     (out_in_image)
  );

endmodule
`default_nettype wire

// ----- design/scanpp_ctrl.sv -----
// Controller: sequences load, rotation iterations, scaling, pixel math and output transfer.
`default_nettype none
module scanpp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_stall,
  output      logic            out_valid,
  input  wire logic            out_stall,
  output      scanpp_pkg::cmd_t cmd
);
  import scanpp_pkg::*;

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.iter      = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        cmd.rotate = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == ITER_W'(ITERS - 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_PIXEL;
      end
      ST_PIXEL: begin
        cmd.pixel = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/scanpp_datapath.sv -----
// Datapath: configuration registers, beam angle, CORDIC rotator, pixel projection, result registers.
`default_nettype none
module scanpp_datapath #(
  parameter int ANGLE_BITS = scanpp_pkg::ANGLE_BITS_DEF,
  parameter int RANGE_BITS = scanpp_pkg::RANGE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire scanpp_pkg::cfg_wr_t                  cfg,
  input  wire scanpp_pkg::cmd_t                     cmd,
  input  wire logic [scanpp_pkg::RANGE_W-1:0]       range_sample,
  input  wire logic                                 scan_start,
  output      logic signed [scanpp_pkg::XPOS_W-1:0] x_pos,
  output      logic signed [scanpp_pkg::XPOS_W-1:0] y_pos,
  output      logic                                 in_range,
  output      logic signed [scanpp_pkg::PIX_W-1:0]  pixel_col,
  output      logic signed [scanpp_pkg::PIX_W-1:0]  pixel_row,
  output      logic                                 in_image
);
  import scanpp_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int RW = (RANGE_BITS < RANGE_W) ? RANGE_BITS : RANGE_W;
  localparam int XW = RW + 18;
  localparam int PW = RW + 2;
  localparam int MW = PW + 1 + SIZE_W + 1;
  localparam int NW = MW + 1;
  localparam logic signed [31:0] RNG_MAX = 32'((64'd1 << RANGE_BITS) - 64'd1);

  // configuration
  logic [AB-1:0]         ang_start_r, ang_step_r;
  logic [RANGE_W-1:0]    min_rng_r, max_rng_r;
  logic [SCALE_W-1:0]    scale_r;
  logic [SCALE_W-1:0]    center_r;
  logic [SIZE_W-1:0]     size_r;
  logic                  flip_r;
  logic signed [31:0]    cfg_sext;

  // working state
  logic [AB-1:0]         angle_r, angle_nxt;
  logic signed [XW-1:0]  x_r, y_r;
  logic signed [Z_W-1:0] z_r;
  logic                  valid_r;
  logic signed [PW-1:0]  xs_r, ys_r;
  logic signed [MW-1:0]  colp_r, rowp_r;

  // result registers
  logic signed [XPOS_W-1:0] x_out_r, y_out_r;
  logic                     rng_out_r, img_out_r;
  logic signed [PIX_W-1:0]  col_out_r, row_out_r;

  // load path
  logic [RW-1:0]          r_in;
  logic [RW+15:0]         r_prod;
  logic [AB+15:0]         ang_ext;
  logic [15:0]            phase;
  logic signed [Z_W-1:0]  z_raw, z_init;
  logic                   quad_flip;
  logic signed [XW-1:0]   x_mag, x_init;
  logic                   valid_in;

  // rotation
  logic signed [XW-1:0]   xsh, ysh;
  logic signed [Z_W-1:0]  atan_v;

  // scaling
  logic signed [XW-17:0]  xf, yf;
  logic signed [31:0]     xf32, yf32, xsat32, ysat32;

  // pixel
  logic signed [PW:0]     xs_e, ys_e, row_src;
  logic signed [SIZE_W:0] scale_s;
  logic signed [NW-1:0]   center_n, col_num, row_num, col_q, row_q, col_sat, row_sat;
  logic signed [NW-1:0]   pmax_n, pmin_n;
  logic signed [PIX_W-1:0] col_fin, row_fin;
  logic                   in_img;
  logic signed [31:0]     xo32, yo32;

  assign cfg_sext = 32'(signed'(cfg.data));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_start_r <= AB'(-32'sd32768);
      ang_step_r  <= AB'(32'sd182);
      min_rng_r   <= '0;
      max_rng_r   <= RANGE_W'(30720);
      scale_r     <= SCALE_W'(500);
      center_r    <= SCALE_W'(360);
      size_r      <= SIZE_W'(720);
      flip_r      <= 1'b1;
    end else if (cfg.wr) begin
      unique case (cfg.idx)
        CFG_ANGLE_START:  ang_start_r <= cfg_sext[AB-1:0];
        CFG_ANGLE_STEP:   ang_step_r  <= cfg_sext[AB-1:0];
        CFG_MIN_RANGE:    min_rng_r   <= cfg.data;
        CFG_MAX_RANGE:    max_rng_r   <= cfg.data;
        CFG_PIXEL_SCALE:  scale_r     <= cfg.data[SCALE_W-1:0];
        CFG_IMAGE_CENTER: center_r    <= cfg.data[SCALE_W-1:0];
        CFG_IMAGE_SIZE:   size_r      <= cfg.data[SIZE_W-1:0];
        CFG_FLIP_ROWS:    flip_r      <= cfg.data[0];
        default:          flip_r      <= flip_r;
      endcase
    end
  end

  // beam angle, quadrant fold, gain product and range test
  always_comb begin
    r_in      = range_sample[RW-1:0];
    r_prod    = (RW + 16)'(r_in) * (RW + 16)'(INV_GAIN);
    angle_nxt = scan_start ? ang_start_r : angle_r + ang_step_r;
    ang_ext   = {angle_nxt, 16'b0};
    phase     = ang_ext[AB+15 -: 16];
    z_raw     = Z_W'(signed'(phase));
    quad_flip = 1'b0;
    z_init    = z_raw;
    if (z_raw > Z_W'(QTR_TURN)) begin
      quad_flip = 1'b1;
      z_init    = z_raw - Z_W'(HALF_TURN);
    end else if (z_raw < -Z_W'(QTR_TURN)) begin
      quad_flip = 1'b1;
      z_init    = z_raw + Z_W'(HALF_TURN);
    end
    x_mag    = signed'(XW'(r_prod));
    x_init   = quad_flip ? -x_mag : x_mag;
    valid_in = (RANGE_W'(r_in) >= min_rng_r) && (RANGE_W'(r_in) < max_rng_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (cmd.load) begin
      angle_r <= angle_nxt;
    end
  end

  assign xsh    = x_r >>> cmd.iter;
  assign ysh    = y_r >>> cmd.iter;
  assign atan_v = atan_lut(cmd.iter);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= x_init;
      y_r     <= '0;
      z_r     <= z_init;
      valid_r <= valid_in;
    end else if (cmd.rotate) begin
      if (z_r >= 0) begin
        x_r <= x_r - ysh;
        y_r <= y_r + xsh;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + ysh;
        y_r <= y_r - xsh;
        z_r <= z_r + atan_v;
      end
    end
  end

  // floor shift and coordinate saturation
  always_comb begin
    xf     = x_r[XW-1:16];
    yf     = y_r[XW-1:16];
    xf32   = 32'(xf);
    yf32   = 32'(yf);
    xsat32 = (xf32 > RNG_MAX) ? RNG_MAX : ((xf32 < -RNG_MAX) ? -RNG_MAX : xf32);
    ysat32 = (yf32 > RNG_MAX) ? RNG_MAX : ((yf32 < -RNG_MAX) ? -RNG_MAX : yf32);
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      xs_r <= xsat32[PW-1:0];
      ys_r <= ysat32[PW-1:0];
    end
  end

  // pixel products
  always_comb begin
    xs_e    = (PW + 1)'(xs_r);
    ys_e    = (PW + 1)'(ys_r);
    row_src = flip_r ? -ys_e : ys_e;
    scale_s = signed'({2'b00, scale_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.pixel) begin
      colp_r <= MW'(xs_e) * MW'(scale_s);
      rowp_r <= MW'(row_src) * MW'(scale_s);
    end
  end

  // offset, truncate toward zero, saturate, bounds test
  always_comb begin
    center_n = signed'(NW'({center_r, 10'b0}));
    col_num  = NW'(colp_r) + center_n;
    row_num  = NW'(rowp_r) + center_n;
    col_q    = ((col_num < 0) ? col_num + NW'(1023) : col_num) >>> 10;
    row_q    = ((row_num < 0) ? row_num + NW'(1023) : row_num) >>> 10;
    pmax_n   = NW'(PIX_MAX);
    pmin_n   = NW'(PIX_MIN);
    col_sat  = (col_q > pmax_n) ? pmax_n : ((col_q < pmin_n) ? pmin_n : col_q);
    row_sat  = (row_q > pmax_n) ? pmax_n : ((row_q < pmin_n) ? pmin_n : row_q);
    col_fin  = col_sat[PIX_W-1:0];
    row_fin  = row_sat[PIX_W-1:0];
    in_img   = valid_r && !col_fin[PIX_W-1] && !row_fin[PIX_W-1] &&
               (col_fin[PIX_W-2:0] < (PIX_W - 1)'(size_r)) &&
               (row_fin[PIX_W-2:0] < (PIX_W - 1)'(size_r));
    xo32     = 32'(xs_r);
    yo32     = 32'(ys_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      x_out_r   <= xo32[XPOS_W-1:0];
      y_out_r   <= yo32[XPOS_W-1:0];
      rng_out_r <= valid_r;
      col_out_r <= col_fin;
      row_out_r <= row_fin;
      img_out_r <= in_img;
    end
  end

  assign x_pos     = x_out_r;
  assign y_pos     = y_out_r;
  assign in_range  = rng_out_r;
  assign pixel_col = col_out_r;
  assign pixel_row = row_out_r;
  assign in_image  = img_out_r;

endmodule
`default_nettype wire
